>>> rtl/core/wefu_pkg.sv
package wefu_pkg;

	// sensor count
	localparam int NUM_SENSORS_DEF = 4;
	localparam int SIDX_W          = 2;

	// field and register widths
	localparam int READ_W    = 19;
	localparam int OFFSET_W  = 19;
	localparam int ALPHA_W   = 10;
	localparam int WEIGHT_W  = 16;
	localparam int PARAM_W   = 45;
	localparam int CFG_IDX_W = 2;
	localparam int SMOOTH_W  = 20;
	localparam int SUM_W     = 29;
	localparam int TERM_W    = 27;

	// parameter register layout
	localparam int OFFSET_LSB = 0;
	localparam int ALPHA_LSB  = 19;
	localparam int WEIGHT_LSB = 29;

	// stream widths
	localparam int S_DATA_W = 24;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 32;

	// shared multiplier and accumulator
	localparam int MUL_A_W = 17;
	localparam int PROD_W  = MUL_A_W + SMOOTH_W;
	localparam int ACC_W   = PROD_W + 1;

	// divide by the scale constant, one byte of quotient per cycle
	localparam int SCALE     = 1000;
	localparam int REM_W     = 10;
	localparam int DIGIT_W   = 8;
	localparam int DIV_W     = 40;
	localparam int DIV_STEPS = DIV_W / DIGIT_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(SCALE);

	localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((64'sd1 <<< (SUM_W-1)) - 1);
	localparam logic signed [SUM_W:0] SUM_MIN = (SUM_W+1)'(-(64'sd1 <<< (SUM_W-1)));

endpackage

>>> rtl/core/weighted_ema_sensor_fusion.sv
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tdata: reading; s_tuser: sensor_index, read_ok;
//                                  s_tlast: sweep_end
// m        out  m_tvalid/m_tready  m_tdata: fused_temp
// cfg      in   cfg_we             cfg_index: register, cfg_data: sensor parameters
//
// One item at a time: a smoothing update makes two passes through the divide-by-1000 unit
// around the shared multiplier. Loading a zero smoothed value skips the first pass, and a
// missing sensor skips both passes and the multiplier.
// Reset clears parameters, smoothed values, last good readings and the sweep sum at once.
// The result register frees the input side; a sweep end waits only while a result is unread.
module weighted_ema_sensor_fusion #(
	parameter int NUM_SENSORS = wefu_pkg::NUM_SENSORS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wefu_pkg::S_DATA_W-1:0]     s_tdata,   // [18:0] reading
	input  logic [wefu_pkg::S_USER_W-1:0]     s_tuser,   // [1:0] sensor_index, [2] read_ok
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wefu_pkg::M_DATA_W-1:0]     m_tdata,   // [28:0] fused_temp
	input  logic                              cfg_we,
	input  logic [wefu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wefu_pkg::PARAM_W-1:0]      cfg_data
);

	localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam int CMP_W = wefu_pkg::SIDX_W + 1;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PREP   = 7'b0000010,
		ST_MUL_A  = 7'b0000100,
		ST_MUL_B  = 7'b0001000,
		ST_DIV_SM = 7'b0010000,
		ST_MUL_W  = 7'b0100000,
		ST_ACCUM  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		DP_DIV_T  = 2'b01,
		DP_NONE   = 2'b10
	} unused_t;

	state_t state_q;
	logic   div_t_q;   // second divide pass in progress (term)

	logic [wefu_pkg::PARAM_W-1:0]         params_q [NUM_SENSORS];
	logic signed [wefu_pkg::SMOOTH_W-1:0] smooth_q [NUM_SENSORS];
	logic signed [wefu_pkg::READ_W-1:0]   good_q   [NUM_SENSORS];
	logic signed [wefu_pkg::SUM_W-1:0]    sweep_q;

	logic [wefu_pkg::SIDX_W-1:0]          sensor_q;
	logic                                 hit_q;
	logic                                 last_q;
	logic signed [wefu_pkg::READ_W-1:0]   temp_q;
	logic signed [wefu_pkg::OFFSET_W-1:0] offset_q;
	logic [wefu_pkg::ALPHA_W-1:0]         alpha_q;
	logic [wefu_pkg::WEIGHT_W-1:0]        weight_q;
	logic signed [wefu_pkg::SMOOTH_W-1:0] diff_q;
	logic signed [wefu_pkg::SMOOTH_W-1:0] old_q;
	logic signed [wefu_pkg::SMOOTH_W-1:0] sm_q;
	logic signed [wefu_pkg::TERM_W-1:0]   term_q;
	logic signed [wefu_pkg::ACC_W-1:0]    acc_q;
	logic                                 div_go_q;
	logic                                 m_tvalid_q;
	logic signed [wefu_pkg::SUM_W-1:0]    out_q;

	logic                                 in_acc;
	logic [wefu_pkg::SIDX_W-1:0]          in_idx;
	logic                                 in_hit;
	logic [IDX_W-1:0]                     in_sel;
	logic [IDX_W-1:0]                     cur_sel;
	logic [wefu_pkg::PARAM_W-1:0]         in_par;
	logic [wefu_pkg::ALPHA_W-1:0]         in_alpha;
	logic signed [wefu_pkg::READ_W-1:0]   in_temp;
	logic signed [wefu_pkg::SMOOTH_W-1:0] diff_d;
	logic signed [wefu_pkg::MUL_A_W-1:0]  mul_a;
	logic signed [wefu_pkg::SMOOTH_W-1:0] mul_b;
	logic signed [wefu_pkg::PROD_W-1:0]   prod;
	logic                                 div_done;
	logic signed [wefu_pkg::ACC_W-1:0]    div_quo;
	logic signed [wefu_pkg::SUM_W:0]      sum_wide;
	logic signed [wefu_pkg::SUM_W-1:0]    sum_sat;
	logic                                 out_free;
	unused_t                              dp_unused;

	assign dp_unused = div_t_q ? DP_DIV_T : DP_NONE;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_idx   = s_tuser[wefu_pkg::SIDX_W-1:0];
	assign in_hit   = ({1'b0, in_idx} < CMP_W'(NUM_SENSORS));
	assign in_sel   = IDX_W'(in_idx);
	assign cur_sel  = IDX_W'(sensor_q);
	assign in_par   = params_q[in_sel];
	assign in_alpha = (in_par[wefu_pkg::ALPHA_LSB +: wefu_pkg::ALPHA_W] > wefu_pkg::ALPHA_MAX)
	                  ? wefu_pkg::ALPHA_MAX : in_par[wefu_pkg::ALPHA_LSB +: wefu_pkg::ALPHA_W];
	assign in_temp  = s_tuser[wefu_pkg::SIDX_W] ? $signed(s_tdata[wefu_pkg::READ_W-1:0])
	                                            : good_q[in_sel];

	assign diff_d = wefu_pkg::SMOOTH_W'(temp_q) - wefu_pkg::SMOOTH_W'(offset_q);

	// shared multiplier operand selection
	always_comb begin
		case (state_q)
			ST_MUL_A: begin
				mul_a = $signed(wefu_pkg::MUL_A_W'(alpha_q));
				mul_b = diff_q;
			end
			ST_MUL_B: begin
				mul_a = $signed(wefu_pkg::MUL_A_W'(wefu_pkg::ALPHA_MAX - alpha_q));
				mul_b = old_q;
			end
			ST_MUL_W: begin
				mul_a = $signed(wefu_pkg::MUL_A_W'(weight_q));
				mul_b = sm_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	wefu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (acc_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// saturating sweep accumulation
	assign sum_wide = (wefu_pkg::SUM_W+1)'(sweep_q) + (wefu_pkg::SUM_W+1)'(term_q);
	always_comb begin
		if (sum_wide > wefu_pkg::SUM_MAX) begin
			sum_sat = wefu_pkg::SUM_W'(wefu_pkg::SUM_MAX);
		end else if (sum_wide < wefu_pkg::SUM_MIN) begin
			sum_sat = wefu_pkg::SUM_W'(wefu_pkg::SUM_MIN);
		end else begin
			sum_sat = sum_wide[wefu_pkg::SUM_W-1:0];
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			div_go_q   <= 1'b0;
			div_t_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			sweep_q    <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (!hit_q) begin
						state_q <= ST_ACCUM;
					end else if (smooth_q[cur_sel] == '0) begin
						state_q <= ST_MUL_W;
					end else begin
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: begin
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					div_go_q <= 1'b1;
					div_t_q  <= 1'b0;
					state_q  <= ST_DIV_SM;
				end
				ST_DIV_SM: begin
					// both divide passes wait here
					if (div_done) begin
						state_q <= div_t_q ? ST_ACCUM : ST_MUL_W;
					end
				end
				ST_MUL_W: begin
					div_go_q <= 1'b1;
					div_t_q  <= 1'b1;
					state_q  <= ST_DIV_SM;
				end
				ST_ACCUM: begin
					if (!last_q) begin
						sweep_q <= sum_sat;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_tvalid_q <= 1'b1;
						sweep_q    <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-sensor state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				params_q[i] <= '0;
				smooth_q[i] <= '0;
				good_q[i]   <= '0;
			end
		end else begin
			if (cfg_we && ({1'b0, cfg_index} < (wefu_pkg::CFG_IDX_W+1)'(NUM_SENSORS))) begin
				params_q[IDX_W'(cfg_index)] <= cfg_data;
			end
			if (in_acc && in_hit) begin
				good_q[in_sel] <= in_temp;
			end
			if (state_q == ST_PREP && hit_q && smooth_q[cur_sel] == '0) begin
				smooth_q[cur_sel] <= diff_d;
			end
			if (state_q == ST_DIV_SM && div_done && !div_t_q) begin
				smooth_q[cur_sel] <= div_quo[wefu_pkg::SMOOTH_W-1:0];
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sensor_q <= in_idx;
			hit_q    <= in_hit;
			last_q   <= s_tlast;
			temp_q   <= in_temp;
			offset_q <= $signed(in_par[wefu_pkg::OFFSET_LSB +: wefu_pkg::OFFSET_W]);
			alpha_q  <= in_alpha;
			weight_q <= in_par[wefu_pkg::WEIGHT_LSB +: wefu_pkg::WEIGHT_W];
		end
		case (state_q)
			ST_PREP: begin
				diff_q <= diff_d;
				old_q  <= smooth_q[cur_sel];
				sm_q   <= diff_d;
				term_q <= '0;
			end
			ST_MUL_A: begin
				acc_q <= wefu_pkg::ACC_W'(prod);
			end
			ST_MUL_B: begin
				acc_q <= acc_q + wefu_pkg::ACC_W'(prod);
			end
			ST_DIV_SM: begin
				if (div_done && !div_t_q) begin
					sm_q <= div_quo[wefu_pkg::SMOOTH_W-1:0];
				end
				if (div_done && div_t_q) begin
					term_q <= div_quo[wefu_pkg::TERM_W-1:0];
				end
			end
			ST_MUL_W: begin
				acc_q <= wefu_pkg::ACC_W'(prod);
			end
			ST_ACCUM: begin
				if (last_q && out_free) begin
					out_q <= sum_sat;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = wefu_pkg::M_DATA_W'($unsigned(out_q));

	// checks
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV_SM)
		else $error("divider finished outside a divide wait");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("second item taken while one is in work");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_ACCUM && last_q))
		else $error("result raised without a sweep end");

	a_sweep_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCUM && last_q && out_free) |=> sweep_q == '0)
		else $error("sweep sum not cleared after emit");

	a_go_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |=> !div_go_q && state_q == ST_DIV_SM)
		else $error("divider start not a single pulse");

	a_tag_valid: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> (dp_unused == DP_DIV_T) == div_t_q)
		else $error("divide pass tag mismatch");

endmodule

>>> rtl/core/wefu_div.sv
// Signed divide by the scale constant, truncating toward zero.
// Long division on the magnitude, DIGIT_W quotient bits per cycle.
module wefu_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [wefu_pkg::ACC_W-1:0] dividend,
	output logic                             done,
	output logic signed [wefu_pkg::ACC_W-1:0] quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic                              neg_q;
	logic [wefu_pkg::DCNT_W-1:0]       cnt_q;
	logic [wefu_pkg::DIV_W-1:0]        sh_q;
	logic [wefu_pkg::DIV_W-1:0]        quo_q;
	logic [wefu_pkg::REM_W-1:0]        rem_q;

	logic [wefu_pkg::REM_W-1:0]        rem_d;
	logic [wefu_pkg::DIGIT_W-1:0]      digit_d;
	logic [wefu_pkg::ACC_W-1:0]        mag_d;

	assign mag_d = dividend[wefu_pkg::ACC_W-1] ? wefu_pkg::ACC_W'(-dividend)
	                                           : wefu_pkg::ACC_W'(dividend);

	// eight restoring steps on a remainder that never reaches twice the divisor
	always_comb begin
		logic [wefu_pkg::REM_W:0] r;
		r = {1'b0, rem_q};
		digit_d = '0;
		for (int k = 0; k < wefu_pkg::DIGIT_W; k++) begin
			r = {r[wefu_pkg::REM_W-1:0], sh_q[wefu_pkg::DIV_W-1-k]};
			if (r >= (wefu_pkg::REM_W+1)'(wefu_pkg::SCALE)) begin
				r = r - (wefu_pkg::REM_W+1)'(wefu_pkg::SCALE);
				digit_d[wefu_pkg::DIGIT_W-1-k] = 1'b1;
			end
		end
		rem_d = r[wefu_pkg::REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wefu_pkg::DCNT_W'(wefu_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[wefu_pkg::ACC_W-1];
			sh_q  <= wefu_pkg::DIV_W'(mag_d);
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << wefu_pkg::DIGIT_W;
			rem_q <= rem_d;
			quo_q <= {quo_q[wefu_pkg::DIV_W-wefu_pkg::DIGIT_W-1:0], digit_d};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q[wefu_pkg::ACC_W-1:0])
	                        :  $signed(quo_q[wefu_pkg::ACC_W-1:0]);

endmodule

>>> verif/testbench.sv
module testbench;

	localparam int IDLE_SETTLE   = 40;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 105;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef enum logic [wefu_pkg::CFG_IDX_W-1:0] {
		REG_SENSOR0, REG_SENSOR1, REG_SENSOR2, REG_SENSOR3
	} param_reg_t;

	typedef struct packed {
		logic [wefu_pkg::SIDX_W-1:0]        sensor;
		logic signed [wefu_pkg::READ_W-1:0] reading;
		logic                               read_ok;
		logic                               sweep_end;
	} sensor_item_t;

	typedef struct packed {
		row_kind_t                      kind;
		logic [wefu_pkg::CFG_IDX_W-1:0] sel;
		logic [wefu_pkg::PARAM_W-1:0]   params;
		sensor_item_t                   item;
		logic                           has_fused;
		logic [wefu_pkg::SUM_W-1:0]     fused;
	} stim_row_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [wefu_pkg::S_DATA_W-1:0]  s_tdata   = '0;
	logic [wefu_pkg::S_USER_W-1:0]  s_tuser   = '0;
	logic                           s_tlast   = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [wefu_pkg::M_DATA_W-1:0]  m_tdata;
	logic                           cfg_we    = 1'b0;
	logic [wefu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [wefu_pkg::PARAM_W-1:0]   cfg_data  = '0;

	// predictor state
	logic [wefu_pkg::PARAM_W-1:0]         par_st    [wefu_pkg::NUM_SENSORS_DEF];
	logic signed [wefu_pkg::SMOOTH_W-1:0] smooth_st [wefu_pkg::NUM_SENSORS_DEF];
	logic signed [wefu_pkg::READ_W-1:0]   good_st   [wefu_pkg::NUM_SENSORS_DEF];
	longint                               sweep_acc;

	logic [wefu_pkg::SUM_W-1:0] pending_fused [$];
	logic [wefu_pkg::SUM_W-1:0] want_fused;
	int                         mismatch_count = 0;
	int                         rx_hold_cycles = 0;
	bit                         rx_quiet       = 1'b0;

	stim_row_t directed_rows [29] = '{
		// reset parameters: every weight is zero
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd0, 19'sd262143, 1'b1, 1'b1}, 1'b1, 29'd0},
		// failed read with no good read yet
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'h40000, 1'b0, 1'b1}, 1'b1, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd2, 19'h40000, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd3, 19'sd0, 1'b1, 1'b1}, 1'b1, 29'd0},
		'{ROW_CFG, REG_SENSOR0, {16'd1000, 10'd1000, 19'd0}, '0, 1'b0, 29'd0},
		// alpha above the scale, most negative offset
		'{ROW_CFG, REG_SENSOR1, {16'd65535, 10'd1023, 19'h40000}, '0, 1'b0, 29'd0},
		'{ROW_CFG, REG_SENSOR2, {16'd65535, 10'd1000, 19'h3FFFF}, '0, 1'b0, 29'd0},
		'{ROW_CFG, REG_SENSOR3, {16'd1, 10'd0, 19'd5}, '0, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd0, 19'sd1234, 1'b1, 1'b1}, 1'b1, 29'd1234},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd0, 19'sd777, 1'b0, 1'b1}, 1'b1, 29'd1234},
		// reading equals offset: smoothed value stays at zero
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'h40000, 1'b1, 1'b1}, 1'b1, 29'd0},
		// full-scale terms held over a long sweep: positive saturation
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'sd262143, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'sd262143, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'sd262143, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'sd262143, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'sd262143, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'sd262143, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'sd262143, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'sd262143, 1'b1, 1'b1}, 1'b1, 29'h0FFFFFFF},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd1, 19'sd5, 1'b0, 1'b1}, 1'b0, 29'd0},
		// and the negative side
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd2, 19'h40000, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd2, 19'h40000, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd2, 19'h40000, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd2, 19'h40000, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd2, 19'h40000, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd2, 19'h40000, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd2, 19'h40000, 1'b1, 1'b0}, 1'b0, 29'd0},
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd2, 19'h40000, 1'b1, 1'b1}, 1'b1, 29'h10000000},
		// small negative term truncates towards zero
		'{ROW_ITEM, REG_SENSOR0, 45'd0, '{2'd3, -19'sd100, 1'b1, 1'b1}, 1'b1, 29'd0}
	};

	weighted_ema_sensor_fusion DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic bit fuse_reading(input sensor_item_t it,
			output logic [wefu_pkg::SUM_W-1:0] fused);
		logic signed [wefu_pkg::OFFSET_W-1:0] off_f;
		logic signed [wefu_pkg::READ_W-1:0]   rd_f;
		longint offset, alpha, weight, temp, diff, sm, term;
		int s;
		fused = '0;
		s = int'(it.sensor);
		if (s < wefu_pkg::NUM_SENSORS_DEF) begin
			off_f  = par_st[s][wefu_pkg::OFFSET_LSB +: wefu_pkg::OFFSET_W];
			offset = longint'(off_f);
			alpha  = longint'(par_st[s][wefu_pkg::ALPHA_LSB +: wefu_pkg::ALPHA_W]);
			weight = longint'(par_st[s][wefu_pkg::WEIGHT_LSB +: wefu_pkg::WEIGHT_W]);
			if (alpha > wefu_pkg::SCALE)
				alpha = longint'(wefu_pkg::SCALE);
			rd_f = it.read_ok ? it.reading : good_st[s];
			good_st[s] = rd_f;
			temp = longint'(rd_f);
			diff = temp - offset;
			if (smooth_st[s] == 0)
				sm = diff;
			else
				sm = (alpha * diff + (wefu_pkg::SCALE - alpha) * longint'(smooth_st[s]))
					/ wefu_pkg::SCALE;
			smooth_st[s] = sm[wefu_pkg::SMOOTH_W-1:0];
			term = (weight * sm) / wefu_pkg::SCALE;
			sweep_acc = sweep_acc + term;
			if (sweep_acc > wefu_pkg::SUM_MAX)
				sweep_acc = longint'(wefu_pkg::SUM_MAX);
			if (sweep_acc < wefu_pkg::SUM_MIN)
				sweep_acc = longint'(wefu_pkg::SUM_MIN);
		end
		if (it.sweep_end) begin
			fused = sweep_acc[wefu_pkg::SUM_W-1:0];
			sweep_acc = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [wefu_pkg::PARAM_W-1:0] pick_params(int phase, int s);
		logic [63:0] r;
		r = {$urandom, $urandom};
		case (phase)
			1: return {16'hFFFF, 10'd1000, (s[0] ? 19'h3FFFF : 19'h40000)};
			2: return {(s == 0 ? 16'd0 : r[15:0]), (s[0] ? 10'd1023 : 10'd0), r[34:16]};
			4: return {r[15:0], 10'($urandom_range(0, 1000)),
				19'($signed($urandom_range(0, 4000)) - 2000)};
			default: return r[wefu_pkg::PARAM_W-1:0];
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatch_count = mismatch_count + 1;
	endtask

	task automatic offer_item(input sensor_item_t it, input bit has_fused,
			input logic [wefu_pkg::SUM_W-1:0] fused_typed);
		logic [wefu_pkg::SUM_W-1:0] fused;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(wefu_pkg::S_DATA_W-wefu_pkg::READ_W){1'b0}}, it.reading};
		s_tuser  <= {it.read_ok, it.sensor};
		s_tlast  <= it.sweep_end;
		do @(posedge clk); while (!s_tready);
		if (fuse_reading(it, fused))
			pending_fused.push_back(has_fused ? fused_typed : fused);
	endtask

	task automatic sender_gap();
		int n;
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 13);
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// items with no result may still be in flight once the queue is empty
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_fused.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic load_params(input logic [wefu_pkg::CFG_IDX_W-1:0] sel,
			input logic [wefu_pkg::PARAM_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		par_st[sel] = val;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fused.size() == 0) begin
				flag_mismatch($sformatf("fused_temp %0d with none expected",
					$signed(m_tdata[wefu_pkg::SUM_W-1:0])));
			end else begin
				want_fused = pending_fused.pop_front();
				if (m_tdata[wefu_pkg::SUM_W-1:0] !== want_fused)
					flag_mismatch($sformatf("fused_temp got %0d want %0d",
						$signed(m_tdata[wefu_pkg::SUM_W-1:0]), $signed(want_fused)));
			end
		end
	end

	// receiver: random stalls, calm stretches, and a long hold when asked
	initial begin
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : 1;
				m_tready <= 1'b1;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		sensor_item_t it;
		int len, sent, burst_left;
		bit calm, paused;
		logic signed [wefu_pkg::OFFSET_W-1:0] off_f;

		for (int s = 0; s < wefu_pkg::NUM_SENSORS_DEF; s++) begin
			par_st[s]    = '0;
			smooth_st[s] = '0;
			good_st[s]   = '0;
		end
		sweep_acc = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				wait_idle();
				load_params(directed_rows[i].sel, directed_rows[i].params);
			end else begin
				offer_item(directed_rows[i].item, directed_rows[i].has_fused,
					directed_rows[i].fused);
				sender_gap();
			end
		end

		burst_left = 0;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			for (int r = 0; r < wefu_pkg::NUM_SENSORS_DEF; r++)
				load_params(r[wefu_pkg::CFG_IDX_W-1:0], pick_params(ph, r));
			if (ph == RANDOM_PHASES - 1)
				rx_quiet = 1'b1;
			// hold the output off while items keep coming, so the input backs up
			if (ph == 2) begin
				rx_hold_cycles = 400;
				burst_left = 40;
			end
			sent = 0;
			paused = 1'b0;
			while (sent < PHASE_ITEMS) begin
				len = ($urandom_range(0, 11) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
				calm = ($urandom_range(0, 3) == 0) || burst_left > 0 || ph == RANDOM_PHASES - 1;
				for (int k = 0; k < len; k++) begin
					it.sensor = wefu_pkg::SIDX_W'($urandom_range(0,
						wefu_pkg::NUM_SENSORS_DEF - 1));
					off_f = par_st[it.sensor][wefu_pkg::OFFSET_LSB +: wefu_pkg::OFFSET_W];
					case ($urandom_range(0, 3))
						0: it.reading = wefu_pkg::READ_W'(off_f
							+ $signed($urandom_range(0, 40)) - 20);
						1: it.reading = $urandom_range(0, 1) ? 19'h3FFFF : 19'h40000;
						default: it.reading = wefu_pkg::READ_W'($urandom);
					endcase
					it.read_ok = ($urandom_range(0, 7) != 0);
					it.sweep_end = (k == len - 1);
					// broken sweeps: stray ends inside a sweep
					if (k != len - 1 && $urandom_range(0, 15) == 0)
						it.sweep_end = 1'b1;
					offer_item(it, 1'b0, '0);
					sent++;
					if (burst_left > 0)
						burst_left--;
					if (!calm)
						sender_gap();
				end
				if (ph == 3 && !paused && sent >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					s_tvalid <= 1'b0;
					do @(posedge clk); while (pending_fused.size() != 0);
				end
			end
		end

		s_tvalid <= 1'b0;
		while (pending_fused.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
